FILE: rtl/core/rbsc_pkg.sv
// ----------------------------------------------------------------------------
// rbsc_pkg
// Types, codes and constants shared by the record bundle stream checker.
// ----------------------------------------------------------------------------
package rbsc_pkg;

	// Bundle header: magic, version, 16-bit count
	localparam logic [7:0] MAGIC [4] = '{8'h54, 8'h4B, 8'h46, 8'h42};
	localparam logic [7:0] HDR_VERSION = 8'h01;
	localparam logic [2:0] HDR_LAST_POS = 3'd6;
	localparam logic [7:0] CHAR_LOW = 8'h21;
	localparam logic [7:0] CHAR_HIGH = 8'h7E;

	localparam logic [7:0] STRING_TYPE_RESET = 8'd33;
	localparam logic [7:0] BLOB_TYPE_RESET = 8'd66;

	typedef enum logic [0:0] {
		REG_STRING_TYPE = 1'b0,
		REG_BLOB_TYPE   = 1'b1
	} reg_index_t;

	typedef enum logic [7:0] {
		PH_HEADER = 8'b0000_0001,
		PH_NS     = 8'b0000_0010,
		PH_KEY    = 8'b0000_0100,
		PH_TYPE   = 8'b0000_1000,
		PH_LENHI  = 8'b0001_0000,
		PH_LENLO  = 8'b0010_0000,
		PH_VALUE  = 8'b0100_0000,
		PH_DONE   = 8'b1000_0000
	} phase_t;

	typedef enum logic [3:0] {
		ROLE_HEADER  = 4'd0,
		ROLE_NS_CHAR = 4'd1,
		ROLE_NS_END  = 4'd2,
		ROLE_KEY_CHAR = 4'd3,
		ROLE_KEY_END = 4'd4,
		ROLE_TYPE    = 4'd5,
		ROLE_LEN_HI  = 4'd6,
		ROLE_LEN_LO  = 4'd7,
		ROLE_VALUE   = 4'd8,
		ROLE_IGNORED = 4'd9
	} role_t;

	typedef enum logic [2:0] {
		E_OK     = 3'd0,
		E_HEADER = 3'd1,
		E_NAME   = 3'd2,
		E_TYPE   = 3'd3,
		E_WIDTH  = 3'd4,
		E_TRUNC  = 3'd5,
		E_TRAIL  = 3'd6
	} err_t;

	typedef struct packed {
		logic [7:0] string_type;
		logic [7:0] blob_type;
	} cfg_t;

	// Frame state, name length kept apart since its width is a parameter
	typedef struct packed {
		phase_t      phase;
		logic [2:0]  hdr_pos;
		logic [15:0] declared_count;
		logic [15:0] records_done;
		logic [7:0]  cur_type;
		logic [15:0] cur_len;
		logic [15:0] val_rem;
		err_t        err;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase: PH_HEADER, hdr_pos: 3'd0, declared_count: 16'd0,
		records_done: 16'd0, cur_type: 8'd0, cur_len: 16'd0,
		val_rem: 16'd0, err: E_OK
	};

	typedef struct packed {
		logic [7:0]  byte_value;
		role_t       byte_role;
		logic [15:0] record_number;
		logic [15:0] value_position;
		logic [7:0]  record_type;
		logic [15:0] record_length;
		logic        record_end;
		logic        frame_end;
		err_t        verdict;
	} result_t;

	// Width in bytes of an integer type code, zero if not an integer type
	function automatic logic [3:0] int_width(input logic [7:0] t);
		logic [3:0] w;
		w = 4'd0;
		if (t[7:4] <= 4'd1) begin
			if (t[3:0] inside {4'd1, 4'd2, 4'd4, 4'd8}) begin
				w = t[3:0];
			end
		end
		return w;
	endfunction

endpackage

FILE: rtl/core/rbsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rbsc_cfg_regs
// Type code registers, written through the plain write port.
// ----------------------------------------------------------------------------
module rbsc_cfg_regs
	import rbsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.string_type <= STRING_TYPE_RESET;
			cfg_q.blob_type <= BLOB_TYPE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STRING_TYPE: cfg_q.string_type <= cfg_data;
				REG_BLOB_TYPE: cfg_q.blob_type <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/rbsc_step.sv
// ----------------------------------------------------------------------------
// rbsc_step
// Per-byte parse logic: next frame state and the result item for one byte.
// ----------------------------------------------------------------------------
module rbsc_step
	import rbsc_pkg::*;
#(
	parameter int NAME_MAX = 15,
	localparam int NL_W = $clog2(NAME_MAX + 1)
) (
	input  state_t           st,
	input  logic [NL_W-1:0]  name_len,
	input  cfg_t             cfg,
	input  logic [7:0]       data,
	input  logic             last,
	output state_t           st_nxt,
	output logic [NL_W-1:0]  name_len_nxt,
	output result_t          res
);

	localparam logic [NL_W-1:0] NAME_LIMIT = NL_W'(NAME_MAX);

	always_comb begin
		state_t          s;
		logic [NL_W-1:0] nl;
		logic [2:0]      pos_n;
		logic            name_end;
		logic            done_rec;
		logic            show_type;
		logic            show_len;
		logic [3:0]      w;
		logic [15:0]     rec_inc;
		err_t            v;

		s = st;
		nl = name_len;
		pos_n = st.hdr_pos + 3'd1;
		name_end = 1'b0;
		done_rec = 1'b0;
		show_type = 1'b0;
		show_len = 1'b0;
		w = int_width(st.cur_type);
		rec_inc = st.records_done + 16'd1;
		res.byte_value = data;
		res.byte_role = ROLE_IGNORED;
		res.record_number = st.records_done;
		res.value_position = 16'd0;

		// shared name check for namespace and key
		if (st.phase == PH_NS || st.phase == PH_KEY) begin
			if (data == 8'd0) begin
				if (name_len == '0) begin
					s.err = E_NAME;
				end else begin
					nl = '0;
					name_end = 1'b1;
				end
			end else if (name_len >= NAME_LIMIT || data < CHAR_LOW || data > CHAR_HIGH) begin
				s.err = E_NAME;
			end else begin
				nl = name_len + NL_W'(1);
			end
		end

		if (st.err == E_OK) begin
			case (st.phase)
				PH_HEADER: begin
					res.byte_role = ROLE_HEADER;
					if (st.hdr_pos < 3'd4) begin
						if (data != MAGIC[st.hdr_pos[1:0]]) s.err = E_HEADER;
					end else if (st.hdr_pos == 3'd4) begin
						if (data != HDR_VERSION) s.err = E_HEADER;
					end else if (st.hdr_pos == 3'd5) begin
						s.declared_count = {data, 8'd0};
					end else begin
						s.declared_count = st.declared_count | {8'd0, data};
					end
					s.hdr_pos = pos_n;
					if (s.err == E_OK && st.hdr_pos == HDR_LAST_POS) begin
						s.phase = (s.declared_count == 16'd0) ? PH_DONE : PH_NS;
					end
				end
				PH_NS: begin
					res.byte_role = (data == 8'd0) ? ROLE_NS_END : ROLE_NS_CHAR;
					s.hdr_pos = st.hdr_pos;
					if (name_end) s.phase = PH_KEY;
				end
				PH_KEY: begin
					res.byte_role = (data == 8'd0) ? ROLE_KEY_END : ROLE_KEY_CHAR;
					if (name_end) s.phase = PH_TYPE;
				end
				PH_TYPE: begin
					res.byte_role = ROLE_TYPE;
					s.cur_type = data;
					show_type = 1'b1;
					if (int_width(data) == 4'd0 && data != cfg.string_type
						&& data != cfg.blob_type) begin
						s.err = E_TYPE;
					end else begin
						s.phase = PH_LENHI;
					end
				end
				PH_LENHI: begin
					res.byte_role = ROLE_LEN_HI;
					show_type = 1'b1;
					s.cur_len = {data, 8'd0};
					s.phase = PH_LENLO;
				end
				PH_LENLO: begin
					res.byte_role = ROLE_LEN_LO;
					show_type = 1'b1;
					show_len = 1'b1;
					s.cur_len = st.cur_len | {8'd0, data};
					if (w != 4'd0 && s.cur_len != {12'd0, w}) begin
						s.err = E_WIDTH;
					end else if (s.cur_len == 16'd0) begin
						done_rec = 1'b1;
					end else begin
						s.val_rem = s.cur_len;
						s.phase = PH_VALUE;
					end
				end
				PH_VALUE: begin
					res.byte_role = ROLE_VALUE;
					show_type = 1'b1;
					show_len = 1'b1;
					res.value_position = st.cur_len - st.val_rem;
					s.val_rem = st.val_rem - 16'd1;
					if (s.val_rem == 16'd0) done_rec = 1'b1;
				end
				default: begin
					s.err = E_TRAIL;
				end
			endcase
		end else begin
			// error already held: byte passes unchecked
			s = st;
			nl = name_len;
		end

		res.record_type = show_type ? s.cur_type : 8'd0;
		res.record_length = show_len ? s.cur_len : 16'd0;
		res.record_end = done_rec;
		res.frame_end = last;
		res.verdict = E_OK;

		if (done_rec) begin
			s.records_done = rec_inc;
			s.phase = (rec_inc == st.declared_count) ? PH_DONE : PH_NS;
			s.cur_type = 8'd0;
			s.cur_len = 16'd0;
			s.val_rem = 16'd0;
		end

		if (last) begin
			v = s.err;
			if (v == E_OK && s.phase != PH_DONE) begin
				v = (s.phase == PH_HEADER) ? E_HEADER : E_TRUNC;
			end
			res.verdict = v;
			s = STATE_RESET;
			nl = '0;
		end

		st_nxt = s;
		name_len_nxt = nl;
	end

endmodule

FILE: rtl/core/record_bundle_stream_checker_top.sv
// ----------------------------------------------------------------------------
// record_bundle_stream_checker_top
// Checks a record bundle byte by byte and tags every byte with its role.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one bundle byte per item, with
//   last_byte set on the final byte of the bundle. Output channel
//   (out_valid/out_stall) gives one result item per input item, in order.
//   An accepted item sits in the input register, is parsed from there and
//   moves to the result register when that register is free or draining.
//   Throughput is one item per cycle unless the receiver stalls; the
//   only feedback is frame state and name length, updated per parsed byte.
//   The result item of the last byte carries frame_end and the verdict, and
//   the frame state returns to its reset value for the next bundle.
//   When the receiver stalls, the result holds and in_stall rises as soon
//   as the input register is also full.
//   Reset (arst_n low) empties both registers, clears the frame state and
//   loads the type code registers with 33 (string) and 66 (blob). The user
//   writes them via cfg_we/cfg_index/cfg_data only while idle, unenforced.
// ----------------------------------------------------------------------------
module record_bundle_stream_checker_top
	import rbsc_pkg::*;
#(
	parameter int NAME_MAX = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  byte_value,
	output logic [3:0]  byte_role,
	output logic [15:0] record_number,
	output logic [15:0] value_position,
	output logic [7:0]  record_type,
	output logic [15:0] record_length,
	output logic        record_end,
	output logic        frame_end,
	output logic [2:0]  verdict
);

	localparam int NL_W = $clog2(NAME_MAX + 1);

	cfg_t            cfg;
	logic            valid_s1;
	logic [7:0]      data_s1;
	logic            last_s1;
	state_t          state_q;
	state_t          state_nxt;
	logic [NL_W-1:0] name_len_q;
	logic [NL_W-1:0] name_len_nxt;
	result_t         res_nxt;
	result_t         res_q;
	logic            out_valid_q;
	logic            adv;
	logic            in_accept;

	rbsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rbsc_step #(
		.NAME_MAX (NAME_MAX)
	) u_step (
		.st           (state_q),
		.name_len     (name_len_q),
		.cfg          (cfg),
		.data         (data_s1),
		.last         (last_s1),
		.st_nxt       (state_nxt),
		.name_len_nxt (name_len_nxt),
		.res          (res_nxt)
	);

	// result register free or being drained this cycle
	assign adv = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			name_len_q <= '0;
			out_valid_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			state_q <= state_nxt;
			name_len_q <= name_len_nxt;
			out_valid_q <= 1'b1;
		end else if (adv) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign byte_value = res_q.byte_value;
	assign byte_role = res_q.byte_role;
	assign record_number = res_q.record_number;
	assign value_position = res_q.value_position;
	assign record_type = res_q.record_type;
	assign record_length = res_q.record_length;
	assign record_end = res_q.record_end;
	assign frame_end = res_q.frame_end;
	assign verdict = res_q.verdict;

`ifndef ASSERT_OFF
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_verdict_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> verdict == E_OK)
		else $error("verdict set on a byte that is not last");

	a_rec_end_role: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_end |-> byte_role == ROLE_LEN_LO || byte_role == ROLE_VALUE)
		else $error("record end on a byte that is not length or value");

	a_frame_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && last_s1 |=> state_q.phase == PH_HEADER && state_q.err == E_OK)
		else $error("frame state not cleared after last byte");
`endif

endmodule
